[design/assert_macros.svh]
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// next-cycle implication that also holds across reset
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[design/dmm_pkg.sv]
// shared types and constants for the dense matrix multiply block
`timescale 1ns / 1ps

package dmm_pkg;

   localparam int VALUE_W = 16;
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int ACC_W   = 40;
   localparam int INDEX_W = 4;
   localparam int DIM_W   = 5;

   typedef enum logic [1:0] {
      ACT_WRITE_A = 2'd0,
      ACT_WRITE_B = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic {
      CSR_ROW_COUNT = 1'b0,
      CSR_COL_COUNT = 1'b1
   } csr_type;

   typedef struct packed {
      logic clear;
      logic term_valid;
   } mac_ctrl_type;

endpackage

[design/dmm_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps

interface dmm_req_if;
   logic                                   valid;
   logic                                   ready;
   dmm_pkg::action_type                    action;
   logic [dmm_pkg::INDEX_W-1:0]            row;
   logic [dmm_pkg::INDEX_W-1:0]            col;
   logic signed [dmm_pkg::VALUE_W-1:0]     value;

   modport source (output valid, action, row, col, value, input ready);
   modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface dmm_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [dmm_pkg::ACC_W-1:0]       product;
   logic                                   status;

   modport source (output valid, product, status, input ready);
   modport sink   (input valid, product, status, output ready);
endinterface

[design/dmm_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module dmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      write_en,
   input  logic [$clog2(DEPTH)-1:0]  write_addr,
   input  logic [WIDTH-1:0]          write_data,
   input  logic [$clog2(DEPTH)-1:0]  read_addr,
   output logic [WIDTH-1:0]          read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

[design/dmm_mac.sv]
// shared multiply-accumulate unit, one term per cycle
`timescale 1ns / 1ps

module dmm_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  dmm_pkg::mac_ctrl_type               ctrl,
   input  logic signed [dmm_pkg::VALUE_W-1:0]  a_value,
   input  logic signed [dmm_pkg::VALUE_W-1:0]  b_value,
   output logic                                busy,
   output logic signed [dmm_pkg::ACC_W-1:0]    acc
);

   import dmm_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   always_comb begin
      prod_in = a_value * b_value;
      acc_in  = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.term_valid;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign busy = prod_valid_ff;
   assign acc  = acc_ff;

endmodule

[design/dense_matrix_multiply_top.sv]
// top level of the dense matrix multiply block
// usage:
//   req_ch carries requests: write an element of A, write an element of B,
//   or read an element of C = A x B. Element values are signed Q8.8.
//   rsp_ch returns one response per read: the exact Q24.16 product and a
//   status bit that flags a row or column outside the configured dimensions.
//   Writes give no response; out-of-range writes are dropped.
//   csr_write_en/csr_index/csr_data set row_count and col_count; the user must
//   do so only while the block is idle, and the block itself does not enforce it.
// read sequencing:
//   an in-range read walks col_count terms (clamped to MAX_DIM) through one
//   shared multiplier, one term per cycle, then drains the multiplier and
//   loads its sum into the output register; an out-of-range read skips the
//   terms and goes straight to the done state. The block takes no request
//   while a read is in flight.
// reset:
//   synchronous, clears the control state and the response valid and sets
//   both dimensions to 16. Stores hold no valid contents until written.
// stalls:
//   a response waits in the output register while rsp_ch.ready is low;
//   writes are still taken meanwhile, and a following read finishes its
//   terms and then waits for the output register to free up.
`timescale 1ns / 1ps

module dense_matrix_multiply_top #(
   parameter int MAX_DIM = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   dmm_req_if.sink                         req_ch,
   dmm_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_en,
   input  dmm_pkg::csr_type                csr_index,
   input  logic [dmm_pkg::DIM_W-1:0]       csr_data
);

   import dmm_pkg::*;

   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW    = $clog2(MAX_DIM + 1);
   localparam int EW    = (CW > DIM_W) ? CW : DIM_W;
   localparam int DEPTH = 2 ** (2 * IW);
   localparam int AW    = 2 * IW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   logic [DIM_W-1:0]        row_count_ff;
   logic [DIM_W-1:0]        col_count_ff;
   logic [EW-1:0]           nr;
   logic [EW-1:0]           nc;

   state_type               state_ff, state_in;
   logic [IW-1:0]           row_ff, row_in;
   logic [IW-1:0]           col_ff, col_in;
   logic [IW-1:0]           k_ff, k_in;
   logic                    err_ff, err_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0] rsp_product_ff, rsp_product_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    req_accept;
   logic                    row_in_nr;
   logic                    row_in_nc;
   logic                    col_in_nc;
   logic                    a_write;
   logic                    b_write;
   logic [AW-1:0]           write_addr;
   logic [AW-1:0]           a_read_addr;
   logic [AW-1:0]           b_read_addr;
   logic [VALUE_W-1:0]      a_data;
   logic [VALUE_W-1:0]      b_data;
   mac_ctrl_type            mac_ctrl;
   logic                    mac_busy;
   logic signed [ACC_W-1:0] mac_acc;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DIM_W'(16);
         col_count_ff <= DIM_W'(16);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_data;
            CSR_COL_COUNT: col_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // dimensions clamped to the store size
   assign nr = (EW'(row_count_ff) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(row_count_ff);
   assign nc = (EW'(col_count_ff) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(col_count_ff);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign row_in_nr = EW'(req_ch.row) < nr;
   assign row_in_nc = EW'(req_ch.row) < nc;
   assign col_in_nc = EW'(req_ch.col) < nc;

   assign a_write    = req_accept && (req_ch.action == ACT_WRITE_A) && row_in_nr && col_in_nc;
   assign b_write    = req_accept && (req_ch.action == ACT_WRITE_B) && row_in_nc && col_in_nc;
   assign write_addr = {IW'(req_ch.row), IW'(req_ch.col)};
   assign a_read_addr = {row_ff, k_ff};
   assign b_read_addr = {k_ff, col_ff};

   dmm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock      (clock),
      .write_en   (a_write),
      .write_addr (write_addr),
      .write_data (req_ch.value),
      .read_addr  (a_read_addr),
      .read_data  (a_data)
   );

   dmm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock      (clock),
      .write_en   (b_write),
      .write_addr (write_addr),
      .write_data (req_ch.value),
      .read_addr  (b_read_addr),
      .read_data  (b_data)
   );

   assign mac_ctrl.clear      = req_accept && (req_ch.action == ACT_READ);
   assign mac_ctrl.term_valid = rd_valid_ff;

   dmm_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .a_value (signed'(a_data)),
      .b_value (signed'(b_data)),
      .busy    (mac_busy),
      .acc     (mac_acc)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      k_in           = k_ff;
      err_in         = err_ff;
      rd_valid_in    = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_product_in = rsp_product_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_ch.action == ACT_READ)) begin
               row_in = IW'(req_ch.row);
               col_in = IW'(req_ch.col);
               k_in   = '0;
               if (row_in_nr && col_in_nc) begin
                  err_in   = 1'b0;
                  state_in = ST_RUN;
               end else begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_RUN: begin
            rd_valid_in = 1'b1;
            k_in        = k_ff + IW'(1);
            if ((EW'(k_ff) + EW'(1)) == nc) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !mac_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_product_in = mac_acc;
               rsp_status_in  = err_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff         <= row_in;
      col_ff         <= col_in;
      k_ff           <= k_in;
      err_ff         <= err_in;
      rsp_product_ff <= rsp_product_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.product = rsp_product_ff;
   assign rsp_ch.status  = rsp_status_ff;

endmodule

[design/dmm_checker.sv]
// port-level checker for the dense matrix multiply block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  dmm_pkg::action_type                 req_action,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [dmm_pkg::ACC_W-1:0]    rsp_product,
   input  logic                                rsp_status
);

   import dmm_pkg::*;

   logic             read_taken;
   logic             rsp_stalled;
   logic [ACC_W:0]   rsp_payload;

   assign read_taken  = req_valid && req_ready && (req_action == ACT_READ);
   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_product, rsp_status};

   // a read keeps the block from taking a request in the following cycle
   `CHK_NEXT(a_read_blocks, clock, reset, read_taken, !req_ready)

   // a flagged response carries a zero product
   `CHK_IMPLY(a_flag_zero, clock, reset, rsp_valid && rsp_status, rsp_product == '0)

   // no response right after reset
   `CHK_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

   // a stalled response holds
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

endmodule

bind dense_matrix_multiply_top dmm_checker u_dmm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_action  (req_ch.action),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_product (rsp_ch.product),
   .rsp_status  (rsp_ch.status)
);

[tb/sv/dense_matrix_multiply_top_test.sv]
// self-checking testbench for the dense matrix multiply block
`timescale 1ns / 1ps

module dense_matrix_multiply_top_test;
   import dmm_pkg::*;

   localparam int MAX_DIM     = 16;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ITEM_TARGET = 550;
   localparam int DRAIN_WAIT  = MAX_DIM + 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      action_type               action;
      logic [INDEX_W-1:0]       row;
      logic [INDEX_W-1:0]       col;
      logic signed [VALUE_W-1:0] value;
   } request_type;

   typedef struct {
      logic signed [ACC_W-1:0] product;
      logic                    status;
   } element_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic               csr_write_en;
   csr_type            csr_index;
   logic [DIM_W-1:0]   csr_data;

   dmm_req_if req_ch ();
   dmm_rsp_if rsp_ch ();

   dense_matrix_multiply_top #(
      .MAX_DIM (MAX_DIM)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // matrix state as the block should hold it
   logic signed [VALUE_W-1:0] a_mem [STORE_DEPTH];
   logic signed [VALUE_W-1:0] b_mem [STORE_DEPTH];
   logic [DIM_W-1:0]          rows_cfg = 5'd16;
   logic [DIM_W-1:0]          cols_cfg = 5'd16;

   // entries the generated requests have loaded so far
   bit a_loaded [STORE_DEPTH];
   bit b_loaded [STORE_DEPTH];

   request_type pending_requests [$];
   element_type c_elements_due [$];
   request_type cur_request;

   int error_count    = 0;
   int pushed_count   = 0;
   int read_count     = 0;
   int write_count    = 0;
   int accepted_count = 0;
   int element_count  = 0;
   int setting_count  = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   bit send_burst     = 1'b0;
   int take_stall     = 0;
   bit take_burst     = 1'b0;

   always #10 clock = ~clock;

   function automatic int unsigned active_dim(logic [DIM_W-1:0] raw);
      return (raw > MAX_DIM) ? MAX_DIM : raw;
   endfunction

   task automatic log_error(string msg);
      $display("error at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void compute_request(request_type it);
      int unsigned nr;
      int unsigned nc;
      longint      acc;
      element_type el;
      nr = active_dim(rows_cfg);
      nc = active_dim(cols_cfg);
      case (it.action)
         ACT_WRITE_A: begin
            if (it.row < nr && it.col < nc) a_mem[it.row * MAX_DIM + it.col] = it.value;
         end
         ACT_WRITE_B: begin
            if (it.row < nc && it.col < nc) b_mem[it.row * MAX_DIM + it.col] = it.value;
         end
         ACT_READ: begin
            if (it.row >= nr || it.col >= nc) begin
               el.product = '0;
               el.status  = 1'b1;
            end else begin
               acc = 0;
               for (int k = 0; k < nc; k++) begin
                  acc += longint'(a_mem[it.row * MAX_DIM + k]) *
                         longint'(b_mem[k * MAX_DIM + it.col]);
               end
               el.product = acc[ACC_W-1:0];
               el.status  = 1'b0;
            end
            c_elements_due.push_back(el);
         end
         default: ;
      endcase
   endfunction

   task automatic check_element(logic signed [ACC_W-1:0] product, logic status);
      element_type want;
      element_count++;
      if (c_elements_due.size() == 0) begin
         log_error($sformatf("response %0d arrived with no read pending", element_count));
      end else begin
         want = c_elements_due.pop_front();
         if (product !== want.product)
            log_error($sformatf("response %0d product: expected %0d, got %0d",
                                element_count, want.product, product));
         if (status !== want.status)
            log_error($sformatf("response %0d status: expected %0b, got %0b",
                                element_count, want.status, status));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid  <= 1'b0;
         req_ch.action <= ACT_NONE;
         req_ch.row    <= '0;
         req_ch.col    <= '0;
         req_ch.value  <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            compute_request(cur_request);
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (send_gap != 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else begin
               cur_request = pending_requests.pop_front();
               req_ch.valid  <= 1'b1;
               req_ch.action <= cur_request.action;
               req_ch.row    <= cur_request.row;
               req_ch.col    <= cur_request.col;
               req_ch.value  <= cur_request.value;
               if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 6);
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_element(rsp_ch.product, rsp_ch.status);
            if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
            take_stall = take_burst ? 0 : $urandom_range(0, 6);
         end else if (take_stall != 0) begin
            take_stall--;
         end
         rsp_ch.ready <= (take_stall == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reads still due",
                  cycle_count, c_elements_due.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic signed [VALUE_W-1:0] draw_value();
      case ($urandom_range(0, 15))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sh0000;
         3:       return 16'shffff;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic void push_request(action_type act, int r, int c,
                                        logic signed [VALUE_W-1:0] v);
      request_type it;
      int unsigned nr;
      int unsigned nc;
      nr = active_dim(rows_cfg);
      nc = active_dim(cols_cfg);
      it.action = act;
      it.row    = INDEX_W'(r);
      it.col    = INDEX_W'(c);
      it.value  = v;
      pending_requests.push_back(it);
      pushed_count++;
      case (act)
         ACT_WRITE_A: begin
            if (r < nr && c < nc) begin
               a_loaded[r * MAX_DIM + c] = 1'b1;
               write_count++;
            end
         end
         ACT_WRITE_B: begin
            if (r < nc && c < nc) begin
               b_loaded[r * MAX_DIM + c] = 1'b1;
               write_count++;
            end
         end
         ACT_READ: begin
            read_count++;
         end
         default: ;
      endcase
   endfunction

   // loads whatever row of a and column of b the read still lacks
   function automatic void read_element(int r, int c);
      int unsigned nr;
      int unsigned nc;
      nr = active_dim(rows_cfg);
      nc = active_dim(cols_cfg);
      if (r < nr && c < nc) begin
         for (int k = 0; k < nc; k++) begin
            if (!a_loaded[r * MAX_DIM + k]) push_request(ACT_WRITE_A, r, k, draw_value());
            if (!b_loaded[k * MAX_DIM + c]) push_request(ACT_WRITE_B, k, c, draw_value());
         end
      end
      push_request(ACT_READ, r, c, draw_value());
   endfunction

   function automatic void random_request();
      int unsigned nr;
      int unsigned nc;
      int          pick;
      nr   = active_dim(rows_cfg);
      nc   = active_dim(cols_cfg);
      pick = $urandom_range(0, 99);
      if (nr == 0 || nc == 0) begin
         push_request(action_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                      $urandom_range(0, 15), draw_value());
      end else if (pick < 30) begin
         push_request(ACT_WRITE_A, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                      draw_value());
      end else if (pick < 50) begin
         push_request(ACT_WRITE_B, $urandom_range(0, nc - 1), $urandom_range(0, nc - 1),
                      draw_value());
      end else if (pick < 85) begin
         read_element($urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
      end else if (pick < 95) begin
         if (nr < MAX_DIM && $urandom_range(0, 1) == 0)
            push_request(pick < 90 ? ACT_READ : ACT_WRITE_A, $urandom_range(nr, 15),
                         $urandom_range(0, 15), draw_value());
         else if (nc < MAX_DIM)
            push_request(action_type'($urandom_range(0, 2)), $urandom_range(0, 15),
                         $urandom_range(nc, 15), draw_value());
         else
            read_element($urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
      end else begin
         push_request(ACT_NONE, $urandom_range(0, 15), $urandom_range(0, 15), draw_value());
      end
   endfunction

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_ch.valid || c_elements_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic set_dims(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
      wait_idle();
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ROW_COUNT;
      csr_data     <= rows;
      @(posedge clock);
      csr_index    <= CSR_COL_COUNT;
      csr_data     <= cols;
      @(posedge clock);
      csr_write_en <= 1'b0;
      rows_cfg = rows;
      cols_cfg = cols;
      setting_count++;
   endtask

   task automatic run_phase(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols, int count);
      int target;
      set_dims(rows, cols);
      target = pushed_count + count;
      while (pushed_count < target) random_request();
   endtask

   initial begin
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_ROW_COUNT;
      csr_data      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full-size dot products at the reset dimensions, largest magnitudes
      for (int k = 0; k < MAX_DIM; k++) begin
         push_request(ACT_WRITE_A, 15, k, 16'sh8000);
         push_request(ACT_WRITE_B, k, 15, 16'sh8000);
      end
      read_element(15, 15);
      for (int k = 0; k < MAX_DIM; k++) push_request(ACT_WRITE_B, k, 0, 16'sh7fff);
      read_element(15, 0);

      // directed 2x2 case, including writes and reads outside the dimensions
      set_dims(5'd2, 5'd2);
      push_request(ACT_WRITE_A, 0, 0, 16'sh7fff);
      push_request(ACT_WRITE_A, 0, 1, 16'sh8000);
      push_request(ACT_WRITE_A, 1, 0, 16'shffff);
      push_request(ACT_WRITE_A, 1, 1, 16'sh0001);
      push_request(ACT_WRITE_B, 0, 0, 16'sh8000);
      push_request(ACT_WRITE_B, 0, 1, 16'sh0000);
      push_request(ACT_WRITE_B, 1, 0, 16'sh8000);
      push_request(ACT_WRITE_B, 1, 1, 16'sh7fff);
      read_element(0, 0);
      read_element(0, 1);
      read_element(1, 0);
      read_element(1, 1);
      push_request(ACT_WRITE_A, 2, 0, 16'sh1234);
      push_request(ACT_WRITE_A, 0, 2, 16'sh4321);
      push_request(ACT_WRITE_B, 2, 1, 16'shdead);
      push_request(ACT_WRITE_B, 15, 15, 16'shbeef);
      push_request(ACT_NONE, 15, 15, 16'shffff);
      read_element(2, 0);
      read_element(0, 2);
      read_element(15, 15);
      read_element(0, 0);

      run_phase(5'd16, 5'd16, 40);
      run_phase(5'd1, 5'd1, 40);
      run_phase(5'd1, 5'd16, 40);
      run_phase(5'd16, 5'd1, 40);
      run_phase(5'd0, 5'd7, 15);
      run_phase(5'd9, 5'd0, 15);
      run_phase(5'd31, 5'd17, 40);
      run_phase(5'd4, 5'd4, 40);
      while (pushed_count < ITEM_TARGET) begin
         rows = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(17, 31))
                                            : DIM_W'($urandom_range(1, 8));
         cols = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(9, 31))
                                            : DIM_W'($urandom_range(1, 8));
         run_phase(rows, cols, 40);
      end
      wait_idle();

      $display("ran %0d requests (%0d loads, %0d reads, rest ignored) over %0d dimension settings",
               accepted_count, write_count, read_count, setting_count);
      $display("checked %0d result elements, %0d errors", element_count, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
